### src/assert_macros.svh
// Assertion macros used by the RTL file d8_flow_direction.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define D8FD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define D8FD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define D8FD_ASSERT(label, clk, rst_n, prop)
`define D8FD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### src/d8fd_pkg.sv
// Shared widths, weights and types of the D8 flow direction block.
package d8fd_pkg;

    localparam int ELEV_BITS   = 24;
    localparam int WEIGHT_BITS = 17;
    localparam int SCORE_BITS  = ELEV_BITS + WEIGHT_BITS;
    localparam int NUM_LANES   = 8;
    localparam int DIR_BITS    = 3;
    localparam int NUM_PAIRS   = NUM_LANES / 2;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_EDGE = 17'd65536;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_DIAG = 17'd46341;

    // Bit i set for a diagonal neighbour, order NW,N,NE,W,E,SW,S,SE.
    localparam logic [NUM_LANES-1:0] DIAG_MASK = 8'b1010_0101;

    localparam logic [ELEV_BITS-1:0] NODATA_RESET = {1'b1, {(ELEV_BITS-1){1'b0}}};

    typedef logic signed [ELEV_BITS-1:0] elev_t;
    typedef logic [SCORE_BITS-1:0]       score_t;
    typedef logic [DIR_BITS-1:0]         dir_t;
    typedef score_t [NUM_LANES-1:0]      score_vec_t;

    typedef struct packed {
        logic load_pair;
        logic load_out;
    } d8fd_ctl_t;

endpackage

### src/d8fd_lane.sv
// One neighbour lane: weighted drop from the centre, registered.
module d8fd_lane
    import d8fd_pkg::*;
(
    input  logic   aclk,
    input  logic   load,
    input  elev_t  center_elev,
    input  elev_t  neigh_elev,
    input  elev_t  nodata_value,
    input  logic   in_grid,
    input  logic   diag,
    output score_t score
);

    logic signed [ELEV_BITS:0] drop;
    logic [ELEV_BITS-1:0]      mag;
    logic [WEIGHT_BITS-1:0]    weight;
    logic                      cand;
    score_t                    score_reg;
    score_t                    score_next;

    always_comb begin
        drop   = {center_elev[ELEV_BITS-1], center_elev} - {neigh_elev[ELEV_BITS-1], neigh_elev};
        mag    = drop[ELEV_BITS-1:0];
        weight = diag ? WEIGHT_DIAG : WEIGHT_EDGE;
        cand   = in_grid && (neigh_elev != nodata_value) && (center_elev != nodata_value)
                 && !drop[ELEV_BITS] && (drop != '0);
        score_next = cand ? (SCORE_BITS'(mag) * SCORE_BITS'(weight)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            score_reg <= score_next;
        end
    end

    assign score = score_reg;

endmodule

### src/d8fd_merge.sv
// Merge tree: pick the largest lane score, earliest lane on ties.
module d8fd_merge
    import d8fd_pkg::*;
(
    input  logic       aclk,
    input  d8fd_ctl_t  ctl,
    input  score_vec_t scores,
    output logic       has_receiver,
    output dir_t       direction
);

    score_t [NUM_PAIRS-1:0] pair_score_reg;
    score_t [NUM_PAIRS-1:0] pair_score_next;
    dir_t   [NUM_PAIRS-1:0] pair_idx_reg;
    dir_t   [NUM_PAIRS-1:0] pair_idx_next;
    score_t                 q0_score;
    score_t                 q1_score;
    score_t                 best_score;
    dir_t                   q0_idx;
    dir_t                   q1_idx;
    dir_t                   best_idx;
    logic                   has_receiver_reg;
    dir_t                   direction_reg;

    always_comb begin
        for (int j = 0; j < NUM_PAIRS; j++) begin
            if (scores[2*j] >= scores[2*j+1]) begin
                pair_score_next[j] = scores[2*j];
                pair_idx_next[j]   = DIR_BITS'(2*j);
            end else begin
                pair_score_next[j] = scores[2*j+1];
                pair_idx_next[j]   = DIR_BITS'(2*j+1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_pair) begin
            pair_score_reg <= pair_score_next;
            pair_idx_reg   <= pair_idx_next;
        end
    end

    always_comb begin
        if (pair_score_reg[0] >= pair_score_reg[1]) begin
            q0_score = pair_score_reg[0];
            q0_idx   = pair_idx_reg[0];
        end else begin
            q0_score = pair_score_reg[1];
            q0_idx   = pair_idx_reg[1];
        end
        if (pair_score_reg[2] >= pair_score_reg[3]) begin
            q1_score = pair_score_reg[2];
            q1_idx   = pair_idx_reg[2];
        end else begin
            q1_score = pair_score_reg[3];
            q1_idx   = pair_idx_reg[3];
        end
        if (q0_score >= q1_score) begin
            best_score = q0_score;
            best_idx   = q0_idx;
        end else begin
            best_score = q1_score;
            best_idx   = q1_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            has_receiver_reg <= (best_score != '0);
            direction_reg    <= best_idx;
        end
    end

    assign has_receiver = has_receiver_reg;
    assign direction    = direction_reg;

endmodule

### src/d8_flow_direction.sv
// Top level of the D8 steepest-descent flow direction block.
//
// Usage:
//   s_ channel carries one 3x3 window per item: s_tdata holds the centre and
//   the eight neighbour elevations, s_tuser the inside mask.
//   m_ channel returns one result per item: m_tuser flags a receiver,
//   m_tdata holds its direction (0..7 = NW,N,NE,W,E,SW,S,SE; 0 if none).
//   cfg_ channel writes the nodata elevation code; it is always ready.
// Pipeline: an accepted item passes the lane product register, the pair
//   compare register and the output register before m_tvalid.
// Throughput: one item per cycle while m_tready is high; eight lanes
//   compute all weighted drops of a window at once.
// Reset: aresetn low empties the pipeline and sets nodata to -8388608.
// Stall: each stage holds while the stage after it is full and stalled;
//   empty stages keep filling, so s_tready drops only when all three
//   stages hold items and m_tready is low.
`include "assert_macros.svh"

module d8_flow_direction
    import d8fd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data,   // nodata_value
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,    // center_elev, elev_nw, elev_n, elev_ne, elev_w,
                                     // elev_e, elev_sw, elev_s, elev_se
    input  logic [7:0]   s_tuser,    // inside_mask
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,    // direction, zero fill
    output logic [0:0]   m_tuser     // has_receiver
);

    elev_t      nodata_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       load1;
    d8fd_ctl_t  ctl;
    elev_t      center_elev;
    score_vec_t scores;
    logic       has_receiver;
    dir_t       direction;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodata_reg <= NODATA_RESET;
        end else if (cfg_valid) begin
            nodata_reg <= cfg_data;
        end
    end

    always_comb begin
        ctl.load_out  = !v3_reg || m_tready;
        ctl.load_pair = !v2_reg || ctl.load_out;
        load1         = !v1_reg || ctl.load_pair;
    end

    assign s_tready = load1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (load1) begin
                v1_reg <= s_tvalid;
            end
            if (ctl.load_pair) begin
                v2_reg <= v1_reg;
            end
            if (ctl.load_out) begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign center_elev = s_tdata[ELEV_BITS-1:0];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        d8fd_lane u_lane (
            .aclk         (aclk),
            .load         (load1),
            .center_elev  (center_elev),
            .neigh_elev   (s_tdata[ELEV_BITS*(i+2)-1 -: ELEV_BITS]),
            .nodata_value (nodata_reg),
            .in_grid      (s_tuser[i]),
            .diag         (DIAG_MASK[i]),
            .score        (scores[i])
        );
    end

    d8fd_merge u_merge (
        .aclk         (aclk),
        .ctl          (ctl),
        .scores       (scores),
        .has_receiver (has_receiver),
        .direction    (direction)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(8-DIR_BITS){1'b0}}, direction};
    assign m_tuser  = has_receiver;

    `D8FD_ASSERT(a_ready_full, aclk, aresetn,
        s_tready == (!v1_reg || !v2_reg || !v3_reg || m_tready))
    `D8FD_ASSERT_NEXT(a_mid_hold, aclk, aresetn,
        v2_reg && v3_reg && !m_tready, v2_reg)
    `D8FD_ASSERT_NEXT(a_first_hold, aclk, aresetn,
        v1_reg && !ctl.load_pair, v1_reg)
    `D8FD_ASSERT(a_none_dir_zero, aclk, aresetn,
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))

endmodule
